// ===== design/crc32msb_pkg.sv =====
// Package with the transfer types, constants and table function of the CRC-32 byte stream core.
`timescale 1ns / 1ps

package crc32msb_pkg;

    localparam logic [31:0] CRC_POLY    = 32'h04C1_1DB7;
    localparam int          CRC_W       = 32;
    localparam int          COUNT_W     = 3;
    localparam logic [2:0]  HEAD_BYTES  = 3'd4;

    // One byte of a message and its end marker.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    // One finished checksum.
    typedef struct packed {
        logic [31:0] crc_value;
        logic        too_short;
    } crc_item_t;

    // Running state of the message in progress.
    typedef struct packed {
        logic [CRC_W-1:0]   crc;
        logic [COUNT_W-1:0] count;
    } crc_state_t;

    // Entry of the non-reflected table for the polynomial; the loop is
    // eight shift-and-conditional-XOR steps and folds into an XOR network.
    function automatic logic [31:0] crc_table_entry(input logic [7:0] idx);
        logic [31:0] v;
        v = {idx, 24'h00_0000};
        for (int k = 0; k < 8; k++)
        begin
            if (v[31])
                v = {v[30:0], 1'b0} ^ CRC_POLY;
            else
                v = {v[30:0], 1'b0};
        end
        return v;
    endfunction

endpackage

// ===== design/crc32msb_step.sv =====
// Combinational update of the CRC state for one byte, with the result on the final byte.
`timescale 1ns / 1ps

module crc32msb_step (
    input  crc32msb_pkg::crc_state_t state,
    input  crc32msb_pkg::byte_item_t item,
    output crc32msb_pkg::crc_state_t state_next,
    output crc32msb_pkg::crc_item_t  result,
    output logic                     result_valid
);
    import crc32msb_pkg::*;

    logic [31:0]        shifted;
    logic [31:0]        crc_upd;
    logic [COUNT_W-1:0] count_upd;
    logic               head_done;

    assign shifted = {state.crc[23:0], item.data_byte};

    always_comb
    begin
        if (state.count < HEAD_BYTES)
        begin
            count_upd = state.count + 3'd1;
            crc_upd   = (count_upd == HEAD_BYTES) ? ~shifted : shifted;
        end
        else
        begin
            count_upd = state.count;
            crc_upd   = shifted ^ crc_table_entry(state.crc[31:24]);
        end
    end

    assign head_done    = (count_upd >= HEAD_BYTES);
    assign result_valid = item.last_byte;

    always_comb
    begin
        result.crc_value = head_done ? ~crc_upd : 32'h0000_0000;
        result.too_short = ~head_done;
        if (item.last_byte)
        begin
            state_next.crc   = '0;
            state_next.count = '0;
        end
        else
        begin
            state_next.crc   = crc_upd;
            state_next.count = count_upd;
        end
    end

endmodule

// ===== design/crc32_msb_first_byte_stream_core.sv =====
// Top level of the CRC-32 (polynomial 04C11DB7, MSB first) byte stream core.
// Path: an accepted byte waits in the input register until it is folded into the running
// state; a final byte's checksum is then loaded into the output register when it is free.
// Throughput: one byte per cycle via the step's table XOR unless a final byte must wait.
// Reset: rst_n clears the running CRC, the byte count and both valid flags at once.
`timescale 1ns / 1ps

module crc32_msb_first_byte_stream_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     byte_valid,
    output logic                     byte_stall,
    input  crc32msb_pkg::byte_item_t byte_item,
    output logic                     crc_valid,
    input  logic                     crc_stall,
    output crc32msb_pkg::crc_item_t  crc_result
);
    import crc32msb_pkg::*;

    // Input register: holds the byte of the latest transfer until it is
    // folded into the running state.
    logic       in_valid_reg;
    logic       in_valid_next;
    byte_item_t in_item_reg;

    // Running state of the message in progress.
    crc_state_t state_reg;
    crc_state_t state_next;

    // Result register, which parts the output handshake from the input side.
    logic       out_valid_reg;
    logic       out_valid_next;
    crc_item_t  out_item_reg;

    crc_item_t  step_result;
    logic       step_result_valid;
    logic       out_free;
    logic       advance;
    logic       byte_accept;

    crc32msb_step u_step (
        .state        (state_reg),
        .item         (in_item_reg),
        .state_next   (state_next),
        .result       (step_result),
        .result_valid (step_result_valid)
    );

    // The result register can take a new checksum when it is empty or is
    // being emptied in this cycle.
    assign out_free = ~out_valid_reg | ~crc_stall;

    // A byte that ends no message never waits; a final byte waits only for
    // room in the result register.
    assign advance     = in_valid_reg & (~step_result_valid | out_free);
    assign byte_stall  = in_valid_reg & ~advance;
    assign byte_accept = byte_valid & ~byte_stall;

    assign in_valid_next  = byte_accept | (in_valid_reg & ~advance);

    always_comb
    begin
        if (advance & step_result_valid)
            out_valid_next = 1'b1;
        else if (~crc_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    // Payload registers load only on their own transfer.
    always_ff @(posedge clk)
    begin
        if (byte_accept)
            in_item_reg <= byte_item;
        if (advance & step_result_valid)
            out_item_reg <= step_result;
    end

    assign crc_valid  = out_valid_reg;
    assign crc_result = out_item_reg;

endmodule

// ===== design/crc32msb_checker.sv =====
// Port-level checker for the CRC-32 byte stream core, bound to the top level.
`timescale 1ns / 1ps

module crc32msb_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     byte_valid,
    input logic                     byte_stall,
    input crc32msb_pkg::byte_item_t byte_item,
    input logic                     crc_valid,
    input logic                     crc_stall,
    input crc32msb_pkg::crc_item_t  crc_result
);
    import crc32msb_pkg::*;

    // A waiting checksum keeps its value until its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        crc_valid && crc_stall |=> crc_valid && $stable(crc_result))
        else $error("checksum changed while stalled");

    // Input back-pressure comes only from a full, stalled output.
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> crc_valid && crc_stall)
        else $error("input stalled without output back-pressure");

    // A short message reports a zero checksum.
    assert property (@(posedge clk) disable iff (!rst_n)
        crc_valid && crc_result.too_short |-> crc_result.crc_value == 32'h0000_0000)
        else $error("short message with non-zero checksum");

    // A final byte that meets a free output in the cycle after its transfer is offered in the cycle after that.
    assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && !byte_stall && byte_item.last_byte) ##1 !crc_stall |=> crc_valid)
        else $error("checksum missing after final byte");

endmodule

bind crc32_msb_first_byte_stream_core crc32msb_checker u_crc32msb_checker (.*);
